// ===== hdl/irt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and constants for the mailbox request tracker.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int ADDR_W                = 32;
  localparam int PENDING_DEPTH_DEF     = 16;
  localparam int OUTSTANDING_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_TX_EMPTY = 2'd1,
    OP_REPLY    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_INSERT,
    S_REPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] req_addr;
  } in_t;

  typedef struct packed {
    logic              send_valid;
    logic [ADDR_W-1:0] send_addr;
    logic              queued;
    logic              complete_valid;
    logic [ADDR_W-1:0] complete_addr;
    logic              unknown_reply;
    logic              overflow;
  } out_t;

endpackage
`default_nettype wire

// ===== hdl/irt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module irt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ipc_request_tracker.sv =====
// Path, accept to result register load: a submit queued or dropped at a full FIFO, a
// transmit-empty with nothing pending and an unused op go straight to the done state; a send
// walks the valid bits for the lowest free slot, after a FIFO pop state for a popped entry; a
// reply makes one table RAM read per entry until a hit or the end of the table.
// Throughput: one request in flight, the next taken once its result moves to the output;
// a held output stalls the input. Reset: slot free, FIFO empty, table invalid; RAMs kept.
`default_nettype none
// ----------------------------------------------------------------------------
// ipc_request_tracker
// Mailbox request tracker: pending FIFO and outstanding table held in RAMs.
// ----------------------------------------------------------------------------
module ipc_request_tracker
  import irt_pkg::*;
#(
  parameter int PENDING_DEPTH     = PENDING_DEPTH_DEF,
  parameter int OUTSTANDING_DEPTH = OUTSTANDING_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int PW  = $clog2(PENDING_DEPTH);
  localparam int OIW = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;

  state_t            state, state_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [OIW:0]      sc, sc_next;
  logic              rd_vld, rd_vld_next;
  logic [OIW-1:0]    rd_idx, rd_idx_next;
  logic              tx_busy, tx_busy_next;
  logic [PW-1:0]     head, head_next;
  logic [PW-1:0]     tail, tail_next;
  logic [PW:0]       pcount, pcount_next;
  logic [OUTSTANDING_DEPTH-1:0] ovalid, ovalid_next;
  out_t              res, res_next;
  logic              out_valid_next;
  out_t              out_data_next;

  logic              p_we, p_re;
  logic [PW-1:0]     p_raddr;
  logic [ADDR_W-1:0] p_rdata;
  logic              t_we, t_re;
  logic [OIW-1:0]    t_waddr, t_raddr;
  logic [ADDR_W-1:0] t_rdata;
  logic [OIW-1:0]    sc_idx;
  logic              hit;

  assign sc_idx = sc[OIW-1:0];
  assign hit    = rd_vld && ovalid[rd_idx] && (t_rdata == addr);

  irt_ram #(.WIDTH(ADDR_W), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (tail),
    .wdata (addr_next),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  irt_ram #(.WIDTH(ADDR_W), .DEPTH(OUTSTANDING_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (addr),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  always_comb begin
    state_next     = state;
    addr_next      = addr;
    sc_next        = sc;
    rd_vld_next    = rd_vld;
    rd_idx_next    = rd_idx;
    tx_busy_next   = tx_busy;
    head_next      = head;
    tail_next      = tail;
    pcount_next    = pcount;
    ovalid_next    = ovalid;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    in_ready       = 1'b0;
    p_we           = 1'b0;
    p_re           = 1'b0;
    p_raddr        = head;
    t_we           = 1'b0;
    t_re           = 1'b0;
    t_waddr        = sc_idx;
    t_raddr        = sc_idx;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          addr_next   = in_data.req_addr;
          res_next    = '0;
          sc_next     = '0;
          rd_vld_next = 1'b0;
          state_next  = S_DONE;
          unique case (in_data.op)
            OP_SUBMIT: begin
              if (!tx_busy) begin
                state_next = S_INSERT;
              end else if (pcount == (PW+1)'(PENDING_DEPTH)) begin
                res_next.overflow = 1'b1;
              end else begin
                p_we            = 1'b1;
                tail_next       = (tail == PW'(PENDING_DEPTH - 1)) ? '0 : tail + 1'b1;
                pcount_next     = pcount + 1'b1;
                res_next.queued = 1'b1;
              end
            end
            OP_TX_EMPTY: begin
              tx_busy_next = 1'b0;
              if (pcount != '0) begin
                p_re        = 1'b1;
                head_next   = (head == PW'(PENDING_DEPTH - 1)) ? '0 : head + 1'b1;
                pcount_next = pcount - 1'b1;
                state_next  = S_POP;
              end
            end
            OP_REPLY: begin
              state_next = S_REPLY;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_POP: begin
        addr_next  = p_rdata;
        state_next = S_INSERT;
      end

      // walk the valid bits for the lowest free slot
      S_INSERT: begin
        if (!ovalid[sc_idx]) begin
          t_we                = 1'b1;
          ovalid_next[sc_idx] = 1'b1;
          tx_busy_next        = 1'b1;
          res_next.send_valid = 1'b1;
          res_next.send_addr  = addr;
          state_next          = S_DONE;
        end else if (sc == (OIW+1)'(OUTSTANDING_DEPTH - 1)) begin
          res_next.overflow = 1'b1;
          state_next        = S_DONE;
        end else begin
          sc_next = sc + 1'b1;
        end
      end

      // issue one table read a cycle, compare the previous one
      S_REPLY: begin
        if (hit) begin
          ovalid_next[rd_idx]     = 1'b0;
          res_next.complete_valid = 1'b1;
          res_next.complete_addr  = addr;
          state_next              = S_DONE;
        end else if (!rd_vld && sc == (OIW+1)'(OUTSTANDING_DEPTH)) begin
          res_next.unknown_reply = 1'b1;
          state_next             = S_DONE;
        end else if (sc != (OIW+1)'(OUTSTANDING_DEPTH)) begin
          t_re        = 1'b1;
          sc_next     = sc + 1'b1;
          rd_vld_next = 1'b1;
          rd_idx_next = sc_idx;
        end else begin
          rd_vld_next = 1'b0;
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tx_busy   <= 1'b0;
      head      <= '0;
      tail      <= '0;
      pcount    <= '0;
      ovalid    <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      state     <= state_next;
      tx_busy   <= tx_busy_next;
      head      <= head_next;
      tail      <= tail_next;
      pcount    <= pcount_next;
      ovalid    <= ovalid_next;
      out_valid <= out_valid_next;
      rd_vld    <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    addr     <= addr_next;
    sc       <= sc_next;
    rd_idx   <= rd_idx_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

endmodule
`default_nettype wire

// ===== verif/ipc_request_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipc_request_tracker_tb
// Self-checking bench for the mailbox request tracker. An opening table of
// requests covers the corner cases from reset. Random traffic then runs in
// bursts with different operation mixes, so that the pending FIFO and the
// outstanding table both fill up and drain. Each result is checked field by
// field against a behavioural tracker kept inside the bench. Both handshakes
// idle at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module ipc_request_tracker_tb;
  import irt_pkg::*;

  localparam int   PEND_DEPTH  = PENDING_DEPTH_DEF;
  localparam int   TBL_DEPTH   = OUTSTANDING_DEPTH_DEF;
  localparam int   RAND_ITEMS  = 1200;
  localparam int   CALM_ITEMS  = 200;
  localparam int   HOLD_CYCLES = 400;
  localparam int   DRAIN_WAIT  = TBL_DEPTH + 8;
  localparam int   CYCLE_LIMIT = 400_000;
  localparam op_t  OP_UNUSED   = op_t'(2'd3);

  typedef enum logic [2:0] {
    RES_PREDICT,
    RES_NONE,
    RES_UNKNOWN,
    RES_SEND,
    RES_QUEUED
  } result_kind_t;

  typedef enum logic [1:0] {
    MODE_MIX,
    MODE_FILL,
    MODE_NO_REPLY,
    MODE_DRAIN
  } traffic_mode_t;

  typedef struct {
    op_t          op;
    logic [31:0]  addr;
    result_kind_t kind;
  } plan_row_t;

  // Walked from reset: slot free, FIFO and table empty.
  plan_row_t opening_plan [21] = '{
    '{OP_UNUSED,   32'hA5A5_5A5A, RES_NONE},
    '{OP_REPLY,    32'hFFFF_FFFF, RES_UNKNOWN},
    '{OP_TX_EMPTY, 32'h1234_5678, RES_NONE},
    '{OP_SUBMIT,   32'h0000_0000, RES_SEND},
    '{OP_SUBMIT,   32'hFFFF_FFFF, RES_QUEUED},
    '{OP_SUBMIT,   32'hFFFF_FFFF, RES_QUEUED},
    '{OP_SUBMIT,   32'h8000_0001, RES_QUEUED},
    '{OP_UNUSED,   32'hFFFF_FFFF, RES_NONE},
    '{OP_TX_EMPTY, 32'h0000_0000, RES_PREDICT},
    '{OP_TX_EMPTY, 32'hFFFF_FFFF, RES_PREDICT},
    '{OP_REPLY,    32'hFFFF_FFFF, RES_PREDICT},
    '{OP_REPLY,    32'h0000_0000, RES_PREDICT},
    '{OP_TX_EMPTY, 32'h0000_0000, RES_PREDICT},
    '{OP_TX_EMPTY, 32'h0000_0000, RES_PREDICT},
    '{OP_TX_EMPTY, 32'h0000_0000, RES_PREDICT},
    '{OP_SUBMIT,   32'h0000_0001, RES_PREDICT},
    '{OP_REPLY,    32'hFFFF_FFFF, RES_PREDICT},
    '{OP_REPLY,    32'hFFFF_FFFF, RES_PREDICT},
    '{OP_REPLY,    32'h8000_0001, RES_PREDICT},
    '{OP_REPLY,    32'h0000_0001, RES_PREDICT},
    '{OP_REPLY,    32'h0000_0000, RES_PREDICT}
  };

  logic [31:0] dup_pool [4] = '{32'h0000_1000, 32'h0000_1040, 32'hDEAD_0000, 32'h7FFF_FFFF};

  logic         clk;
  logic         rst       = 1'b1;
  logic         in_valid  = 1'b0;
  logic         in_ready;
  in_t          in_data   = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  out_t         out_data;
  result_kind_t row_kind  = RES_PREDICT;

  // Tracker state mirrored by the bench
  logic         slot_busy;
  logic [31:0]  pend_fifo [$];
  logic [31:0]  tbl_addr [TBL_DEPTH];
  logic         tbl_live [TBL_DEPTH];

  out_t         awaited_results [$];
  int           errors       = 0;
  int           cycles       = 0;
  int           n_requests   = 0;
  int           n_sent       = 0;
  int           n_queued     = 0;
  int           n_complete   = 0;
  int           n_unknown    = 0;
  int           n_overflow   = 0;
  bit           calm         = 1'b0;
  bit           hold_req     = 1'b0;

  ipc_request_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("FAIL ipc_request_tracker");
      $finish;
    end
  end

  // Write addr to the mailbox if the table has room; lowest free slot wins.
  function automatic void mailbox_send(input logic [31:0] addr, inout out_t res);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (!tbl_live[i]) begin
        tbl_live[i]   = 1'b1;
        tbl_addr[i]   = addr;
        slot_busy     = 1'b1;
        res.send_valid = 1'b1;
        res.send_addr  = addr;
        return;
      end
    end
    res.overflow = 1'b1;
  endfunction

  function automatic out_t track_request(input in_t req);
    out_t        res;
    logic [31:0] head;
    bit          hit;
    res = '0;
    hit = 1'b0;
    case (req.op)
      OP_SUBMIT: begin
        if (!slot_busy) begin
          mailbox_send(req.req_addr, res);
        end else if (pend_fifo.size() >= PEND_DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          pend_fifo.push_back(req.req_addr);
          res.queued = 1'b1;
        end
      end
      OP_TX_EMPTY: begin
        slot_busy = 1'b0;
        if (pend_fifo.size() > 0) begin
          head = pend_fifo.pop_front();
          mailbox_send(head, res);
        end
      end
      OP_REPLY: begin
        for (int i = 0; i < TBL_DEPTH && !hit; i++) begin
          if (tbl_live[i] && tbl_addr[i] == req.req_addr) begin
            tbl_live[i] = 1'b0;
            hit = 1'b1;
          end
        end
        if (hit) begin
          res.complete_valid = 1'b1;
          res.complete_addr  = req.req_addr;
        end else begin
          res.unknown_reply = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Check results in order, then log the request taken on the same edge.
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (rst) begin
      slot_busy = 1'b0;
      pend_fifo.delete();
      foreach (tbl_live[i]) tbl_live[i] = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: %p", out_data);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("send_valid",     32'(want.send_valid),     32'(out_data.send_valid));
          check_field("send_addr",      want.send_addr,           out_data.send_addr);
          check_field("queued",         32'(want.queued),         32'(out_data.queued));
          check_field("complete_valid", 32'(want.complete_valid),
                      32'(out_data.complete_valid));
          check_field("complete_addr",  want.complete_addr,       out_data.complete_addr);
          check_field("unknown_reply",  32'(want.unknown_reply),  32'(out_data.unknown_reply));
          check_field("overflow",       32'(want.overflow),       32'(out_data.overflow));
        end
      end
      if (in_valid && in_ready) begin
        want = track_request(in_data);
        // Hand-written results from the opening table take precedence
        case (row_kind)
          RES_NONE: want = '0;
          RES_UNKNOWN: begin
            want = '0;
            want.unknown_reply = 1'b1;
          end
          RES_SEND: begin
            want = '0;
            want.send_valid = 1'b1;
            want.send_addr  = in_data.req_addr;
          end
          RES_QUEUED: begin
            want = '0;
            want.queued = 1'b1;
          end
          default: ;
        endcase
        awaited_results.push_back(want);
        n_requests++;
        n_sent     += int'(want.send_valid);
        n_queued   += int'(want.queued);
        n_complete += int'(want.complete_valid);
        n_unknown  += int'(want.unknown_reply);
        n_overflow += int'(want.overflow);
      end
    end
  end

  initial begin : receiver
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // Hold off long enough for the input side to back up
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task automatic offer(input in_t req, input result_kind_t kind);
    in_valid <= 1'b1;
    in_data  <= req;
    row_kind <= kind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_addr();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return dup_pool[$urandom_range(0, 3)];
    if (pick == 3) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    return $urandom;
  endfunction

  function automatic in_t make_request(input traffic_mode_t mode);
    in_t req;
    int  roll;
    int  p_sub;
    int  p_tx;
    int  p_rep;
    int  live_idx [$];
    case (mode)
      MODE_FILL:     begin p_sub = 75; p_tx = 10; p_rep = 13; end
      MODE_NO_REPLY: begin p_sub = 50; p_tx = 48; p_rep = 0;  end
      MODE_DRAIN:    begin p_sub = 10; p_tx = 35; p_rep = 53; end
      default:       begin p_sub = 40; p_tx = 30; p_rep = 25; end
    endcase
    roll = $urandom_range(0, 99);
    req.req_addr = $urandom;
    if (roll < p_sub) begin
      req.op       = OP_SUBMIT;
      req.req_addr = pick_addr();
    end else if (roll < p_sub + p_tx) begin
      req.op = OP_TX_EMPTY;
    end else if (roll < p_sub + p_tx + p_rep) begin
      req.op = OP_REPLY;
      for (int i = 0; i < TBL_DEPTH; i++) if (tbl_live[i]) live_idx.push_back(i);
      // Mostly answer a live request; otherwise a stray address
      if (live_idx.size() > 0 && $urandom_range(0, 4) != 0)
        req.req_addr = tbl_addr[live_idx[$urandom_range(0, live_idx.size() - 1)]];
      else
        req.req_addr = pick_addr();
    end else begin
      req.op = OP_UNUSED;
    end
    return req;
  endfunction

  initial begin : stimulus
    in_t           req;
    traffic_mode_t mode;
    int            burst_left;
    mode       = MODE_MIX;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_plan[i]) begin
      req.op       = opening_plan[i].op;
      req.req_addr = opening_plan[i].addr;
      offer(req, opening_plan[i].kind);
      sender_pause();
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (burst_left == 0) begin
        mode       = traffic_mode_t'((mode + 1) % 4);
        burst_left = $urandom_range(30, 80);
      end
      burst_left--;
      if (n == RAND_ITEMS / 2) hold_req = 1'b1;
      if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      offer(make_request(mode), RES_PREDICT);
      sender_pause();
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests through the tracker: %0d sent, %0d queued, %0d completed,",
             n_requests, n_sent, n_queued, n_complete);
    $display("%0d unknown replies and %0d overflow drops, with a long output hold-off.",
             n_unknown, n_overflow);
    if (errors == 0) begin
      $display("PASS ipc_request_tracker");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL ipc_request_tracker");
    end
    $finish;
  end

endmodule
